[hw/rtl/configurable_crc32_byte_engine_unit_defines.svh]
`ifndef CONFIGURABLE_CRC32_BYTE_ENGINE_UNIT_DEFINES_SVH
`define CONFIGURABLE_CRC32_BYTE_ENGINE_UNIT_DEFINES_SVH

// clocked check, off while in reset
`define CRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition checked in the cycle after a trigger
`define CRC_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

[hw/rtl/crc32b_pkg.sv]
package crc32b_pkg;

	localparam int CRC_W = 32;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_POLY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FXOR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REFLECT = 2'd3;

	localparam logic [CRC_W-1:0] POLY_RESET = 32'h04c1_1db7;
	localparam logic [CRC_W-1:0] INIT_RESET = 32'hffff_ffff;
	localparam logic [CRC_W-1:0] FXOR_RESET = 32'hffff_ffff;
	localparam logic [CRC_W-1:0] CRC_RESET = 32'hffff_ffff;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              first_byte;
		logic              last_byte;
	} in_t;

	typedef struct packed {
		logic [CRC_W-1:0] running_crc;
		logic [CRC_W-1:0] finished_crc;
		logic [CRC_W-1:0] wire_word;
		logic             is_final;
	} out_t;

endpackage

[hw/rtl/crc32b_fold.sv]
module crc32b_fold
	import crc32b_pkg::*;
(
	input  logic [CRC_W-1:0]  crc_in,
	input  logic [BYTE_W-1:0] data,
	input  logic [CRC_W-1:0]  poly,
	input  logic              reflect,
	output logic [CRC_W-1:0]  crc_out
);

	logic [CRC_W-1:0] poly_rev;

	always_comb begin
		for (int i = 0; i < CRC_W; i++) begin
			poly_rev[i] = poly[CRC_W-1-i];
		end
	end

	always_comb begin
		logic [CRC_W-1:0] c;
		c = crc_in;
		if (reflect) begin
			c[BYTE_W-1:0] = c[BYTE_W-1:0] ^ data;
			for (int k = 0; k < BYTE_W; k++) begin
				c = c[0] ? ((c >> 1) ^ poly_rev) : (c >> 1);
			end
		end else begin
			c[CRC_W-1 -: BYTE_W] = c[CRC_W-1 -: BYTE_W] ^ data;
			for (int k = 0; k < BYTE_W; k++) begin
				c = c[CRC_W-1] ? ((c << 1) ^ poly) : (c << 1);
			end
		end
		crc_out = c;
	end

endmodule

[hw/rtl/configurable_crc32_byte_engine_unit.sv]
// Byte-wide CRC-32 engine with programmable polynomial, initial value, final XOR and bit
// order. It takes one byte per clock while the output is not stalled, with valid/ready on
// both sides, and each byte gives one result, registered in the input stage and then in
// the output register. The running CRC lives in a single-entry memory that is read every
// cycle; the value written by the previous byte is forwarded, so consecutive bytes need
// no interlock. The eight-step shift/XOR fold of one byte is combinational and sets the
// critical path. Program the registers only while no byte is in flight.
module configurable_crc32_byte_engine_unit
	import crc32b_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CRC_W-1:0]     cfg_data
);

	`include "configurable_crc32_byte_engine_unit_defines.svh"

	logic [CRC_W-1:0] poly_q;
	logic [CRC_W-1:0] init_q;
	logic [CRC_W-1:0] fxor_q;
	logic             reflect_q;

	logic [CRC_W-1:0] crc_mem [0:0];
	logic [CRC_W-1:0] rd_q;
	logic             rd_valid_q;
	logic             mem_valid_q;
	logic [CRC_W-1:0] fwd_q;
	logic             fwd_valid_q;

	logic             valid_s1;
	in_t              item_s1;
	logic             adv_s1;

	logic [CRC_W-1:0] crc_cur;
	logic [CRC_W-1:0] crc_base;
	logic [CRC_W-1:0] crc_new;
	logic [CRC_W-1:0] fin;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET;
			init_q <= INIT_RESET;
			fxor_q <= FXOR_RESET;
			reflect_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLY: poly_q <= cfg_data;
				REG_INIT: init_q <= cfg_data;
				REG_FXOR: fxor_q <= cfg_data;
				REG_REFLECT: reflect_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv_s1 = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// state memory, read every cycle
	always_ff @(posedge clk) begin
		rd_q <= crc_mem[0];
		if (adv_s1) begin
			crc_mem[0] <= crc_new;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fwd_q <= crc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_valid_q <= 1'b0;
			rd_valid_q <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= mem_valid_q;
			fwd_valid_q <= adv_s1;
			if (adv_s1) begin
				mem_valid_q <= 1'b1;
			end
		end
	end

	// forward the value written at the last edge
	always_comb begin
		if (fwd_valid_q) begin
			crc_cur = fwd_q;
		end else if (rd_valid_q) begin
			crc_cur = rd_q;
		end else begin
			crc_cur = CRC_RESET;
		end
	end

	assign crc_base = item_s1.first_byte ? init_q : crc_cur;

	crc32b_fold u_fold (
		.crc_in  (crc_base),
		.data    (item_s1.data_byte),
		.poly    (poly_q),
		.reflect (reflect_q),
		.crc_out (crc_new)
	);

	assign fin = crc_new ^ fxor_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data.running_crc <= crc_new;
			out_data.finished_crc <= fin;
			out_data.wire_word <= reflect_q ? fin : {fin[7:0], fin[15:8], fin[23:16], fin[31:24]};
			out_data.is_final <= item_s1.last_byte;
		end
	end

	`CRC_ASSERT_NEXT(a_adv_fills_out, adv_s1, out_valid, "result lost after fold")
	`CRC_ASSERT_NEXT(a_state_tracks_out, adv_s1, crc_cur == out_data.running_crc,
		"running crc state differs from last result")
	`CRC_ASSERT(a_stall_cause, !in_ready |-> (valid_s1 && out_valid && !out_ready),
		"input stalled without a full pipeline")

endmodule

[bench/configurable_crc32_byte_engine_unit_tb.sv]
module configurable_crc32_byte_engine_unit_tb;
	import crc32b_pkg::*;

	localparam int PHASE_ITEMS = 148;
	localparam int NUM_PHASES = 8;
	localparam int WATCHDOG_LIMIT = 5000;

	class crc_predictor;
		logic [CRC_W-1:0] poly;
		logic [CRC_W-1:0] init_value;
		logic [CRC_W-1:0] final_xor;
		logic             reflect;
		logic [CRC_W-1:0] crc_state;
		out_t             expected_crcs[$];
		int               errors;

		function new();
			poly = POLY_RESET;
			init_value = INIT_RESET;
			final_xor = FXOR_RESET;
			reflect = 1'b1;
			crc_state = CRC_RESET;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CRC_W-1:0] val);
			case (idx)
				REG_POLY: poly = val;
				REG_INIT: init_value = val;
				REG_FXOR: final_xor = val;
				REG_REFLECT: reflect = val[0];
				default: ;
			endcase
		endfunction

		function logic [CRC_W-1:0] fold(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
			logic [CRC_W-1:0] rev_poly;
			for (int k = 0; k < CRC_W; k++)
				rev_poly[k] = poly[CRC_W-1-k];
			if (reflect) begin
				c = c ^ {24'b0, b};
				for (int k = 0; k < 8; k++)
					c = c[0] ? ((c >> 1) ^ rev_poly) : (c >> 1);
			end else begin
				c = c ^ {b, 24'b0};
				for (int k = 0; k < 8; k++)
					c = c[CRC_W-1] ? ((c << 1) ^ poly) : (c << 1);
			end
			return c;
		endfunction

		function void take_byte(in_t item);
			out_t want;
			if (item.first_byte)
				crc_state = init_value;
			crc_state = fold(crc_state, item.data_byte);
			want.running_crc = crc_state;
			want.finished_crc = crc_state ^ final_xor;
			want.wire_word = reflect ? want.finished_crc :
				{want.finished_crc[7:0], want.finished_crc[15:8],
				 want.finished_crc[23:16], want.finished_crc[31:24]};
			want.is_final = item.last_byte;
			expected_crcs.push_back(want);
		endfunction

		function void check_crc(out_t got);
			out_t want;
			if (expected_crcs.size() == 0) begin
				$display("%0t unexpected result: expected none actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_crcs.pop_front();
			if (got.running_crc !== want.running_crc) begin
				$display("%0t running_crc mismatch: expected %h actual %h",
					$time, want.running_crc, got.running_crc);
				errors++;
			end
			if (got.finished_crc !== want.finished_crc) begin
				$display("%0t finished_crc mismatch: expected %h actual %h",
					$time, want.finished_crc, got.finished_crc);
				errors++;
			end
			if (got.wire_word !== want.wire_word) begin
				$display("%0t wire_word mismatch: expected %h actual %h",
					$time, want.wire_word, got.wire_word);
				errors++;
			end
			if (got.is_final !== want.is_final) begin
				$display("%0t is_final mismatch: expected %b actual %b",
					$time, want.is_final, got.is_final);
				errors++;
			end
		endfunction

		function bit drained();
			return expected_crcs.size() == 0;
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_t                  in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CRC_W-1:0]     cfg_data = '0;

	int send_idle = 0;
	int recv_stall = 0;
	int quiet_cycles = 0;
	crc_predictor crc_model;

	configurable_crc32_byte_engine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			crc_model.check_crc(out_data);
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic in_t make_item(logic [7:0] b, logic f, logic l);
		in_t item;
		item.data_byte = b;
		item.first_byte = f;
		item.last_byte = l;
		return item;
	endfunction

	task automatic send_item(input in_t item);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		crc_model.take_byte(item);
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_item(make_item(8'($urandom_range(255)), i == 0, i == len - 1));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (!crc_model.drained())
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CRC_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		crc_model.set_reg(idx, val);
	endtask

	task automatic program_engine(input logic [CRC_W-1:0] p, input logic [CRC_W-1:0] i,
		input logic [CRC_W-1:0] f, input logic r);
		write_reg(REG_POLY, p);
		write_reg(REG_INIT, i);
		write_reg(REG_FXOR, f);
		write_reg(REG_REFLECT, {31'b0, r});
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(input int count);
		int sent;
		int len;
		bit paused;
		sent = 0;
		paused = 0;
		while (sent < count) begin
			if (!paused && sent >= count / 2) begin
				drain();
				paused = 1;
			end
			if ($urandom_range(99) < 85) begin
				len = $urandom_range(1, 12);
				send_message(len);
				sent += len;
			end else begin
				send_item(make_item(8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1))));
				sent++;
			end
		end
	endtask

	initial begin
		crc_model = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no first byte after reset, then continuation past a last byte
		send_item(make_item(8'h00, 1'b0, 1'b0));
		send_item(make_item(8'hff, 1'b0, 1'b0));
		send_item(make_item(8'h5a, 1'b0, 1'b1));
		send_item(make_item(8'hff, 1'b0, 1'b0));
		// check string
		for (int i = 0; i < 9; i++)
			send_item(make_item(8'(8'h31 + i), i == 0, i == 8));
		send_item(make_item(8'h00, 1'b1, 1'b1));
		send_item(make_item(8'hff, 1'b1, 1'b1));
		send_item(make_item(8'h80, 1'b1, 1'b0));
		send_item(make_item(8'h01, 1'b0, 1'b1));
		// reload in the middle of a message
		send_item(make_item(8'ha5, 1'b1, 1'b0));
		send_item(make_item(8'h3c, 1'b1, 1'b0));
		send_item(make_item(8'hc3, 1'b0, 1'b0));

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			case (p)
				1: program_engine(32'h04c1_1db7, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
				2: program_engine(32'h1edc_6f41, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
				3: program_engine(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
				4: program_engine(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000, 1'b0);
				5: program_engine($urandom, $urandom, $urandom, 1'b1);
				6: program_engine(32'h8000_0000, $urandom, 32'hffff_ffff, 1'b0);
				7: program_engine(POLY_RESET, INIT_RESET, FXOR_RESET, 1'b1);
				default: ;
			endcase
			case (p % 4)
				0: begin
					send_idle = 0;
					recv_stall = 0;
				end
				1: begin
					send_idle = 81;
					recv_stall = 0;
				end
				2: begin
					send_idle = 0;
					recv_stall = 81;
				end
				default: begin
					send_idle = 32;
					recv_stall = 32;
				end
			endcase
			// carry the running crc across the settings change
			if (p == 1 || p == 6) begin
				send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b0));
				send_item(make_item(8'($urandom_range(255)), 1'b0, 1'b1));
			end
			run_random(PHASE_ITEMS);
		end

		drain();
		repeat (8) @(posedge clk);
		if (crc_model.errors == 0 && crc_model.drained()) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/crc32b_pkg.sv
hw/rtl/crc32b_fold.sv
hw/rtl/configurable_crc32_byte_engine_unit.sv
bench/configurable_crc32_byte_engine_unit_tb.sv
